[hdl/mpu_pkg.sv]
// ----------------------------------------------------------------------------
// mpu_pkg: shared types and constants for the memory protection unit
// Region count, register offsets, request kinds, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mpu_pkg;

	localparam int REGIONS = 8;
	localparam int IDX_W   = $clog2(REGIONS);

	// request kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;

	// register byte offsets
	localparam logic [7:0] OFF_TYPE = 8'h00;
	localparam logic [7:0] OFF_CTRL = 8'h04;
	localparam logic [7:0] OFF_RNR  = 8'h08;
	localparam logic [7:0] OFF_RBAR = 8'h0C;
	localparam logic [7:0] OFF_RASR = 8'h10;

	// smallest size code that forms a usable region
	localparam logic [4:0] SIZE_MIN = 5'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FIN
	} mpu_state_t;

	typedef struct packed {
		logic capture;     // latch the incoming request
		logic exec;        // register access, or check setup
		logic walk_start;  // point the region walk at the top region
		logic walk;        // test one region
		logic load_out;    // move the result into the output register
	} mpu_cmd_t;

	typedef struct packed {
		logic is_check;
		logic unit_on;
		logic hit;
		logic walk_last;
		logic out_free;
	} mpu_stat_t;

endpackage

`default_nettype wire

[hdl/memory_protection_unit.sv]
// ----------------------------------------------------------------------------
// memory_protection_unit: eight-region access checker with register port
// Flow: IDLE captures a request, EXEC does the register access or check set-up,
// WALK tests the regions of an enabled check, FIN loads the output register, and
// out_valid rises once the result is in it. The next request is taken only once
// the unit is back in IDLE, after the result has entered the output register.
// Reset (arst_n low): unit disabled, region number 0, all regions cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_protection_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  reg_offset,
	input  wire logic [31:0] write_data,
	input  wire logic [31:0] access_address,
	input  wire logic [3:0]  access_bytes,
	input  wire logic        is_store,
	input  wire logic        is_privileged,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic             permitted
);
	import mpu_pkg::*;

	// The controller only sequences: IDLE takes a request, EXEC performs the
	// register read/write or sets up a check, WALK tests one region per cycle
	// from region 7 down until a hit or region 0, FIN waits for the output
	// register to free up. The output register lets a finished result wait
	// on out_stall while the unit is already back in IDLE for the next request.
	mpu_cmd_t  cmd;
	mpu_stat_t stat;

	mpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: holds CTRL, RNR and the per-region base/attribute/enable
	// registers, a single 33-bit containment comparator that the walk uses for
	// every region, the AP decode and the output register.
	mpu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.reg_offset     (reg_offset),
		.write_data     (write_data),
		.access_address (access_address),
		.access_bytes   (access_bytes),
		.is_store       (is_store),
		.is_privileged  (is_privileged),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.permitted      (permitted)
	);

endmodule

`default_nettype wire

[hdl/mpu_ctrl.sv]
// ----------------------------------------------------------------------------
// mpu_ctrl: sequencing FSM
// Accepts one request, runs the register access or the region walk, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire mpu_pkg::mpu_stat_t stat,
	output mpu_pkg::mpu_cmd_t      cmd
);
	import mpu_pkg::*;

	mpu_state_t state_q;
	mpu_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_check && stat.unit_on) begin
					cmd.walk_start = 1'b1;
					state_nxt      = ST_WALK;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.hit || stat.walk_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// walk never runs past the bottom region
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && stat.walk_last) |=> (state_q == ST_FIN))
		else $error("region walk did not end at region zero");

	// a result is never pushed over one that is still stalled
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

[hdl/mpu_dp.sv]
// ----------------------------------------------------------------------------
// mpu_dp: register file, region comparator and output register
// One region is examined per cycle during a check walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mpu_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mpu_pkg::mpu_cmd_t cmd,
	output mpu_pkg::mpu_stat_t     stat,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        reg_offset,
	input  wire logic [31:0]       write_data,
	input  wire logic [31:0]       access_address,
	input  wire logic [3:0]        access_bytes,
	input  wire logic              is_store,
	input  wire logic              is_privileged,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            read_data,
	output logic                   permitted
);
	import mpu_pkg::*;

	// captured request
	logic [1:0]  kind_q;
	logic [7:0]  off_q;
	logic [31:0] wdata_q;
	logic [31:0] addr_q;
	logic [3:0]  bytes_q;
	logic        store_q;
	logic        priv_q;

	// architectural state
	logic [2:0]  ctrl_q;
	logic [IDX_W-1:0] rnr_q;
	logic [26:0] base_q [REGIONS];
	logic [27:0] attr_q [REGIONS];
	logic        en_q   [REGIONS];

	// walk and result
	logic [IDX_W-1:0] walk_idx_q;
	logic [31:0] rd_q;
	logic        ok_q;
	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic        permitted_q;

	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] wr_idx;
	logic [26:0] sel_base;
	logic [27:0] sel_attr;
	logic        sel_en;
	logic [4:0]  sel_size;
	logic [2:0]  sel_ap;
	logic [32:0] reg_start;
	logic [32:0] reg_len;
	logic [32:0] reg_end;
	logic [32:0] acc_end;
	logic        hit;
	logic        ap_ok;
	logic [31:0] reg_rdata;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			off_q   <= reg_offset;
			wdata_q <= write_data;
			addr_q  <= access_address;
			bytes_q <= access_bytes;
			store_q <= is_store;
			priv_q  <= is_privileged;
		end
	end

	// one read port: the walk index during a check walk, else the selected region
	assign sel_idx  = cmd.walk ? walk_idx_q : rnr_q;
	assign sel_base = base_q[sel_idx];
	assign sel_attr = attr_q[sel_idx];
	assign sel_en   = en_q[sel_idx];
	assign sel_size = sel_attr[4:0];
	assign sel_ap   = sel_attr[25:23];

	// region [base, base + 2^(size+1)) against [addr, addr + bytes), 33 bits wide
	assign reg_start = {1'b0, sel_base, 5'b0};
	assign reg_len   = 33'd2 << sel_size;
	assign reg_end   = reg_start + reg_len;
	assign acc_end   = {1'b0, addr_q} + 33'(bytes_q);
	assign hit = sel_en && (sel_size >= SIZE_MIN)
		&& ({1'b0, addr_q} >= reg_start) && (acc_end <= reg_end);

	always_comb begin
		case (sel_ap)
			3'd1:    ap_ok = priv_q;
			3'd2:    ap_ok = priv_q || !store_q;
			3'd3:    ap_ok = 1'b1;
			3'd5:    ap_ok = priv_q && !store_q;
			3'd6:    ap_ok = !store_q;
			3'd7:    ap_ok = !store_q;
			default: ap_ok = 1'b0;
		endcase
	end

	always_comb begin
		case (off_q)
			OFF_TYPE: reg_rdata = 32'(REGIONS) << 8;
			OFF_CTRL: reg_rdata = {29'b0, ctrl_q};
			OFF_RNR:  reg_rdata = 32'(rnr_q);
			OFF_RBAR: reg_rdata = {sel_base, 2'b0, rnr_q};
			OFF_RASR: reg_rdata = {3'b0, sel_attr, sel_en};
			default:  reg_rdata = '0;
		endcase
	end

	// RBAR with VALID set retargets the region number before the write
	assign wr_idx = (off_q == OFF_RBAR && wdata_q[4]) ? wdata_q[IDX_W-1:0] : rnr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			rnr_q  <= '0;
			for (int i = 0; i < REGIONS; i++) begin
				base_q[i] <= '0;
				attr_q[i] <= '0;
				en_q[i]   <= 1'b0;
			end
		end else if (cmd.exec && kind_q == KIND_WRITE) begin
			case (off_q)
				OFF_CTRL: ctrl_q <= wdata_q[2:0];
				OFF_RNR:  rnr_q  <= wdata_q[IDX_W-1:0];
				OFF_RBAR: begin
					rnr_q          <= wr_idx;
					base_q[wr_idx] <= wdata_q[31:5];
				end
				OFF_RASR: begin
					attr_q[wr_idx] <= wdata_q[28:1];
					en_q[wr_idx]   <= wdata_q[0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q <= (kind_q == KIND_READ) ? reg_rdata : '0;
			ok_q <= (kind_q == KIND_CHECK);  // disabled unit permits
		end else if (cmd.walk) begin
			if (hit) begin
				ok_q <= ap_ok;
			end else if (walk_idx_q == '0) begin
				ok_q <= ctrl_q[2] && priv_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q <= '0;
		end else if (cmd.walk_start) begin
			walk_idx_q <= IDX_W'(REGIONS - 1);
		end else if (cmd.walk && walk_idx_q != '0) begin
			walk_idx_q <= walk_idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q <= rd_q;
			permitted_q <= ok_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign permitted = permitted_q;

	assign stat.is_check  = (kind_q == KIND_CHECK);
	assign stat.unit_on   = ctrl_q[0];
	assign stat.hit       = hit;
	assign stat.walk_last = (walk_idx_q == '0);
	assign stat.out_free  = !out_valid_q || !out_stall;

	a_walk_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_start |=> (walk_idx_q == IDX_W'(REGIONS - 1)))
		else $error("walk did not start at the top region");

	a_walk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk && !hit && walk_idx_q != '0) |=> (walk_idx_q == $past(walk_idx_q) - 1'b1))
		else $error("walk index skipped a region");

endmodule

`default_nettype wire

[tb/tb_memory_protection_unit.sv]
// ----------------------------------------------------------------------------
// tb_memory_protection_unit: self-checking bench for the protection unit
// A table of directed requests runs first, then about a thousand random
// requests built mostly as region set-ups followed by checks aimed at the
// region edges. A shadow copy of the unit's registers predicts each result,
// and every handed-off result is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_memory_protection_unit;

	import mpu_pkg::*;

	// request kind the unit answers with an all-zero result
	localparam logic [1:0] KIND_NONE = 2'd3;

	// access-permission codes (RASR bits 26:24)
	localparam logic [2:0] AP_NO_ACCESS = 3'd0;
	localparam logic [2:0] AP_PRIV_RW   = 3'd1;
	localparam logic [2:0] AP_USER_RO   = 3'd2;
	localparam logic [2:0] AP_FULL      = 3'd3;
	localparam logic [2:0] AP_RESERVED  = 3'd4;
	localparam logic [2:0] AP_PRIV_RO   = 3'd5;
	localparam logic [2:0] AP_RO        = 3'd6;
	localparam logic [2:0] AP_RO_ALIAS  = 3'd7;

	// CTRL bit positions
	localparam int CTRL_ENABLE     = 0;
	localparam int CTRL_PRIVDEFENA = 2;

	// RBAR bit that makes bits 2:0 select the region
	localparam int RBAR_VALID_BIT = 4;

	localparam logic [31:0] BASE_BITS = 32'hFFFF_FFE0;
	localparam logic [31:0] ATTR_BITS = 32'h1FFF_FFFE;

	localparam int RANDOM_ITEMS    = 1000;
	localparam int PAUSE_EVERY     = 250;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int IDLE_LIMIT      = 2000;
	localparam int TAIL_CYCLES     = 24;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  off;
		logic [31:0] wdata;
		logic [31:0] addr;
		logic [3:0]  nbytes;
		logic        store;
		logic        priv;
	} mpu_request_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        ok;
	} mpu_result_t;

	// one line of the directed table; res only counts when known is set
	typedef struct packed {
		mpu_request_t rq;
		logic         known;
		mpu_result_t  res;
	} plan_row_t;

	// ------------------------------------------------------------------
	// DUT hookup; every input holds a known value from time zero
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [1:0]  kind           = KIND_READ;
	logic [7:0]  reg_offset     = OFF_TYPE;
	logic [31:0] write_data     = '0;
	logic [31:0] access_address = '0;
	logic [3:0]  access_bytes   = '0;
	logic        is_store       = 1'b0;
	logic        is_privileged  = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [31:0] read_data;
	logic        permitted;

	memory_protection_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.reg_offset     (reg_offset),
		.write_data     (write_data),
		.access_address (access_address),
		.access_bytes   (access_bytes),
		.is_store       (is_store),
		.is_privileged  (is_privileged),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.permitted      (permitted)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the unit's programmable state
	// ------------------------------------------------------------------
	logic [2:0]  shadow_ctrl;
	logic [2:0]  shadow_rnr;
	logic [31:0] shadow_base [REGIONS];
	logic [31:0] shadow_attr [REGIONS];
	logic        shadow_on   [REGIONS];

	// results still owed by the unit, oldest first
	mpu_result_t pending_results [$];

	int  mismatches    = 0;
	int  results_seen  = 0;
	int  idle_cycles   = 0;
	int  n_reads       = 0;
	int  n_writes      = 0;
	int  n_checks      = 0;
	int  n_unused      = 0;
	int  n_granted     = 0;
	int  n_pauses      = 0;
	bit  sender_idles  = 1'b1;
	bit  squeeze_armed = 1'b0;

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// AP table: does this code let the access through?
	function automatic logic ap_grants(logic [2:0] ap, logic st, logic pv);
		case (ap)
			AP_PRIV_RW:  return pv;
			AP_USER_RO:  return pv || !st;
			AP_FULL:     return 1'b1;
			AP_PRIV_RO:  return pv && !st;
			AP_RO,
			AP_RO_ALIAS: return !st;
			// no access, and the reserved code, both deny
			AP_NO_ACCESS,
			AP_RESERVED: return 1'b0;
			default:     return 1'b0;
		endcase
	endfunction

	// Region walk, top region first. Ends are formed at 33 bits so a
	// region or an access running up to 4 GiB never wraps.
	function automatic logic access_allowed(logic [31:0] addr, logic [3:0] nb,
			logic st, logic pv);
		logic [32:0] lo;
		logic [32:0] hi;
		logic [32:0] stop_at;
		logic [4:0]  code;
		if (!shadow_ctrl[CTRL_ENABLE])
			return 1'b1;
		stop_at = {1'b0, addr} + {29'd0, nb};
		for (int i = REGIONS - 1; i >= 0; i--) begin
			code = shadow_attr[i][5:1];
			if (shadow_on[i] && code >= SIZE_MIN) begin
				lo = {1'b0, shadow_base[i]};
				hi = lo + (33'd1 << (code + 1));
				if ({1'b0, addr} >= lo && stop_at <= hi)
					return ap_grants(shadow_attr[i][26:24], st, pv);
			end
		end
		// background map: privileged only, and only with PRIVDEFENA
		return shadow_ctrl[CTRL_PRIVDEFENA] && pv;
	endfunction

	// Applies one request to the shadow state and returns what the unit
	// must hand back for it.
	function automatic mpu_result_t apply_to_shadow(mpu_request_t rq);
		mpu_result_t res;
		res = '0;
		case (rq.op)
			KIND_READ: begin
				case (rq.off)
					OFF_TYPE: res.rdata = 32'(REGIONS) << 8;
					OFF_CTRL: res.rdata = {29'd0, shadow_ctrl};
					OFF_RNR:  res.rdata = {29'd0, shadow_rnr};
					OFF_RBAR: res.rdata = shadow_base[shadow_rnr] | {29'd0, shadow_rnr};
					OFF_RASR: res.rdata = shadow_attr[shadow_rnr]
						| {31'd0, shadow_on[shadow_rnr]};
					default:  res.rdata = '0;
				endcase
			end
			KIND_WRITE: begin
				case (rq.off)
					OFF_CTRL: shadow_ctrl = rq.wdata[2:0];
					OFF_RNR:  shadow_rnr = rq.wdata[2:0];
					OFF_RBAR: begin
						// region field 8..15 wraps onto its low three bits
						if (rq.wdata[RBAR_VALID_BIT])
							shadow_rnr = rq.wdata[2:0];
						shadow_base[shadow_rnr] = rq.wdata & BASE_BITS;
					end
					OFF_RASR: begin
						shadow_attr[shadow_rnr] = rq.wdata & ATTR_BITS;
						shadow_on[shadow_rnr] = rq.wdata[0];
					end
					// TYPE and unknown offsets are ignored
					default: ;
				endcase
			end
			KIND_CHECK: res.ok = access_allowed(rq.addr, rq.nbytes, rq.store, rq.priv);
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------
	function automatic mpu_request_t rd_req(logic [7:0] off);
		mpu_request_t rq;
		rq = '0;
		rq.op = KIND_READ;
		rq.off = off;
		return rq;
	endfunction

	function automatic mpu_request_t wr_req(logic [7:0] off, logic [31:0] data);
		mpu_request_t rq;
		rq = '0;
		rq.op = KIND_WRITE;
		rq.off = off;
		rq.wdata = data;
		return rq;
	endfunction

	function automatic mpu_request_t chk_req(logic [31:0] addr, logic [3:0] nb,
			logic st, logic pv);
		mpu_request_t rq;
		rq = '0;
		rq.op = KIND_CHECK;
		rq.addr = addr;
		rq.nbytes = nb;
		rq.store = st;
		rq.priv = pv;
		return rq;
	endfunction

	function automatic plan_row_t row(mpu_request_t rq, logic known, logic [31:0] rd,
			logic ok);
		plan_row_t pr;
		pr.rq = rq;
		pr.known = known;
		pr.res.rdata = rd;
		pr.res.ok = ok;
		return pr;
	endfunction

	// Gap before the next request: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_idles || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// ------------------------------------------------------------------
	// Request side. Payload changes only at the falling edge; acceptance
	// is seen at the rising edge. The valid line is written at most once
	// per falling edge, so back-to-back requests keep it high.
	// ------------------------------------------------------------------
	task automatic send_request(input mpu_request_t rq, input logic known,
			input mpu_result_t typed, input int gap);
		mpu_result_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		kind           <= rq.op;
		reg_offset     <= rq.off;
		write_data     <= rq.wdata;
		access_address <= rq.addr;
		access_bytes   <= rq.nbytes;
		is_store       <= rq.store;
		is_privileged  <= rq.priv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// shadow advances even when the table gives the answer directly
		predicted = apply_to_shadow(rq);
		pending_results.push_back(known ? typed : predicted);
		case (rq.op)
			KIND_READ:  n_reads++;
			KIND_WRITE: n_writes++;
			KIND_CHECK: begin
				n_checks++;
				if (predicted.ok)
					n_granted++;
			end
			default:    n_unused++;
		endcase
	endtask

	// Sender goes quiet until every owed result has been handed off.
	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		n_pauses++;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		plan_row_t    plan [$];
		mpu_request_t rq;
		mpu_result_t  none;
		logic [31:0]  wd;
		logic [4:0]   code;
		longint unsigned span;
		longint unsigned spot;
		int effective, next_pause, mode_left, burst_left;
		int r, n, j, sel;
		bit squeezed;

		none = '0;
		shadow_ctrl = '0;
		shadow_rnr = '0;
		for (int i = 0; i < REGIONS; i++) begin
			shadow_base[i] = '0;
			shadow_attr[i] = '0;
			shadow_on[i] = 1'b0;
		end

		// --- directed table -------------------------------------------
		// reset values, the disabled unit, the unused kind
		plan.push_back(row(rd_req(OFF_TYPE), 1'b1, 32'h0000_0800, 1'b0));
		plan.push_back(row(rd_req(OFF_CTRL), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(chk_req(32'hFFFF_FFFF, 4'd8, 1'b1, 1'b0), 1'b1, 32'h0, 1'b1));
		rq = '1;
		rq.op = KIND_NONE;
		plan.push_back(row(rq, 1'b1, 32'h0, 1'b0));
		// unknown offset read; writes to TYPE and to an unknown offset
		plan.push_back(row(rd_req(8'hFF), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(wr_req(OFF_TYPE, 32'hFFFF_FFFF), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(wr_req(8'h14, 32'hFFFF_FFFF), 1'b1, 32'h0, 1'b0));
		// region 0: whole 4 GiB, read-only; RASR bits above 28 dropped
		plan.push_back(row(wr_req(OFF_RBAR, 32'h0000_0010), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(wr_req(OFF_RASR, 32'hF600_FF3F), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(rd_req(OFF_RASR), 1'b1, 32'h1600_FF3F, 1'b0));
		// enable with PRIVDEFENA; upper bits dropped
		plan.push_back(row(wr_req(OFF_CTRL, 32'hFFFF_FFFD), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(rd_req(OFF_CTRL), 1'b1, 32'h5, 1'b0));
		// last eight bytes of the address space
		plan.push_back(row(chk_req(32'hFFFF_FFF8, 4'd8, 1'b0, 1'b0), 1'b1, 32'h0, 1'b1));
		plan.push_back(row(chk_req(32'hFFFF_FFF8, 4'd8, 1'b1, 1'b1), 1'b1, 32'h0, 1'b0));
		// region field 15 wraps to region 7, top 32-byte block
		plan.push_back(row(wr_req(OFF_RBAR, 32'hFFFF_FFFF), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(rd_req(OFF_RBAR), 1'b1, 32'hFFFF_FFE7, 1'b0));
		plan.push_back(row(rd_req(OFF_RNR), 1'b1, 32'h7, 1'b0));
		// smallest usable size, reserved AP code
		plan.push_back(row(wr_req(OFF_RASR, 32'h0400_0009), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(chk_req(32'hFFFF_FFF8, 4'd8, 1'b0, 1'b1), 1'b1, 32'h0, 1'b0));
		// access running past the end of memory; zero-length at the top byte
		plan.push_back(row(chk_req(32'hFFFF_FFFC, 4'd8, 1'b0, 1'b0), 1'b0, 32'h0, 1'b0));
		plan.push_back(row(chk_req(32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0), 1'b0, 32'h0, 1'b0));
		// size code below the minimum: region 7 drops out
		plan.push_back(row(wr_req(OFF_RASR, 32'h0300_0007), 1'b1, 32'h0, 1'b0));
		// RBAR with VALID clear goes through RNR
		plan.push_back(row(wr_req(OFF_RNR, 32'hFFFF_FFFA), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(wr_req(OFF_RBAR, 32'h4000_0000), 1'b1, 32'h0, 1'b0));
		plan.push_back(row(rd_req(OFF_RBAR), 1'b1, 32'h4000_0002, 1'b0));

		@(posedge arst_n);
		foreach (plan[i])
			send_request(plan[i].rq, plan[i].known, plan[i].res, pick_gap());
		drain_results;

		// --- random part ----------------------------------------------
		// Mostly region set-ups and checks aimed at region edges; some
		// CTRL traffic and reads; the rest is noise that may be ignored.
		effective  = 0;
		next_pause = PAUSE_EVERY;
		mode_left  = 0;
		burst_left = 0;
		squeezed   = 1'b0;
		while (effective < RANDOM_ITEMS) begin
			if (effective >= next_pause) begin
				drain_results;
				next_pause += PAUSE_EVERY;
			end
			// midway: result side holds off while we keep pushing
			if (!squeezed && effective >= RANDOM_ITEMS / 2) begin
				squeezed = 1'b1;
				squeeze_armed = 1'b1;
				sender_idles = 1'b0;
				burst_left = 60;
			end
			if (burst_left > 0) begin
				burst_left--;
			end else if (mode_left == 0) begin
				sender_idles = ($urandom_range(0, 3) != 0);
				mode_left = $urandom_range(20, 60);
			end else begin
				mode_left--;
			end

			r = $urandom_range(0, 99);
			if (r < 30) begin
				// program one region: RBAR (VALID or via RNR), then RASR, then a read back
				wd = $urandom;
				if ($urandom_range(0, 9) < 3) begin
					j = $urandom_range(0, REGIONS - 1);
					wd[31:5] = shadow_base[j][31:5] + 27'($urandom_range(0, 7));
				end
				if ($urandom_range(0, 9) < 7) begin
					wd[RBAR_VALID_BIT] = 1'b1;
				end else begin
					wd[RBAR_VALID_BIT] = 1'b0;
					send_request(wr_req(OFF_RNR, $urandom), 1'b0, none, pick_gap());
					effective++;
				end
				send_request(wr_req(OFF_RBAR, wd), 1'b0, none, pick_gap());
				wd = $urandom;
				sel = $urandom_range(0, 99);
				if (sel < 45)
					wd[5:1] = 5'($urandom_range(4, 9));
				else if (sel < 65)
					wd[5:1] = 5'($urandom_range(10, 31));
				else if (sel < 80)
					wd[5:1] = 5'($urandom_range(0, 3));
				wd[0] = ($urandom_range(0, 9) != 0);
				send_request(wr_req(OFF_RASR, wd), 1'b0, none, pick_gap());
				send_request(rd_req($urandom_range(0, 1) ? OFF_RBAR : OFF_RASR), 1'b0,
					none, pick_gap());
				effective += 3;
			end else if (r < 70) begin
				// burst of checks near a region's start, end or inside, some at random addresses
				n = $urandom_range(1, 6);
				repeat (n) begin
					j = $urandom_range(0, REGIONS - 1);
					code = shadow_attr[j][5:1];
					span = (code < SIZE_MIN) ? 64'd32 : (64'd1 << (code + 1));
					spot = shadow_base[j];
					sel = $urandom_range(0, 99);
					if (sel < 25)
						spot = spot + 8 - $urandom_range(0, 16);
					else if (sel < 50)
						spot = spot + span - $urandom_range(0, 12);
					else if (sel < 80)
						spot = spot + ({$urandom, $urandom} % span);
					else
						spot = $urandom;
					send_request(chk_req(spot[31:0],
						($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
							: 4'($urandom_range(9, 15)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
						1'b0, none, pick_gap());
					effective++;
				end
			end else if (r < 80) begin
				// CTRL: mostly enabled, other bits random, then read back
				wd = $urandom;
				wd[CTRL_ENABLE] = ($urandom_range(0, 99) < 85);
				send_request(wr_req(OFF_CTRL, wd), 1'b0, none, pick_gap());
				send_request(rd_req(OFF_CTRL), 1'b0, none, pick_gap());
				effective += 2;
			end else if (r < 90) begin
				case ($urandom_range(0, 4))
					0:       rq = rd_req(OFF_TYPE);
					1:       rq = rd_req(OFF_CTRL);
					2:       rq = rd_req(OFF_RNR);
					3:       rq = rd_req(OFF_RBAR);
					default: rq = rd_req(OFF_RASR);
				endcase
				send_request(rq, 1'b0, none, pick_gap());
				effective++;
			end else begin
				// noise: any kind, stray or misaligned offsets, random fields
				rq.op     = 2'($urandom_range(0, 3));
				rq.off    = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(1, 3)) + 8'(4 * $urandom_range(0, 4));
				rq.wdata  = $urandom;
				rq.addr   = $urandom;
				rq.nbytes = 4'($urandom_range(0, 15));
				rq.store  = 1'($urandom_range(0, 1));
				rq.priv   = 1'($urandom_range(0, 1));
				send_request(rq, 1'b0, none, pick_gap());
				effective++;
			end
		end

		// --- wind down ------------------------------------------------
		drain_results;
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d reads, %0d writes, %0d checks, %0d unused-kind requests",
			n_reads, n_writes, n_checks, n_unused);
		$display("%0d results compared, %0d checks granted, %0d sender pauses, one long hold-off",
			results_seen, n_granted, n_pauses);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern switches at random between none, light and
	// bursty; once, on request, one long hold-off that lets the unit back up
	// into its request port.
	// ------------------------------------------------------------------
	initial begin : result_side
		int stall_left;
		int mode;
		int mode_left;
		int r;
		stall_left = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (squeeze_armed) begin
				squeeze_armed = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			r = $urandom_range(0, 99);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (mode != 0 && r < (mode == 1 ? 15 : 30)) begin
				// mostly the short length range, now and then a long stretch
				stall_left = (r < 3) ? $urandom_range(7, 29) : $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// In-order result check against the oldest owed result
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		mpu_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_data %h permitted %b", read_data, permitted);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (read_data !== want.rdata) begin
					$error("read_data: expected %h, got %h", want.rdata, read_data);
					mismatches++;
				end
				if (permitted !== want.ok) begin
					$error("permitted: expected %b, got %b", want.ok, permitted);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no handshake on either side ends the run
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

`default_nettype wire
